@@ rtl/core/aes_pkg.sv @@
package aes_pkg;

   localparam int unsigned NUM_ROUNDS = 10;
   localparam int unsigned BLOCK_W = 128;

   typedef logic [BLOCK_W-1:0] block_type;
   typedef logic [7:0] byte_type;

   typedef enum logic {
      OP_ENCRYPT = 1'b0,
      OP_DECRYPT = 1'b1
   } op_type;

   typedef enum logic {
      REG_KEY_HIGH = 1'b0,
      REG_KEY_LOW  = 1'b1
   } reg_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] INV_SBOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   localparam logic [7:0] RCON [NUM_ROUNDS] = '{
      8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
   };

   // byte i of a block sits at bits [127-8i -: 8]
   function automatic byte_type get_byte(block_type b, int i);
      return b[BLOCK_W-1-8*i -: 8];
   endfunction

   function automatic byte_type xtime(byte_type a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic block_type sub_shift(block_type s);
      block_type t;
      int r, c;
      t = '0;
      for (c = 0; c < 4; c++)
         for (r = 0; r < 4; r++)
            t[BLOCK_W-1-8*(c*4+r) -: 8] = SBOX[get_byte(s, ((c + r) & 3)*4 + r)];
      return t;
   endfunction

   function automatic block_type inv_shift_sub(block_type s);
      block_type t;
      int r, c;
      t = '0;
      for (c = 0; c < 4; c++)
         for (r = 0; r < 4; r++)
            t[BLOCK_W-1-8*(c*4+r) -: 8] = INV_SBOX[get_byte(s, ((c - r + 4) & 3)*4 + r)];
      return t;
   endfunction

   function automatic block_type mix_cols(block_type s);
      block_type t;
      byte_type a0, a1, a2, a3;
      int c;
      t = '0;
      for (c = 0; c < 4; c++) begin
         a0 = get_byte(s, c*4);
         a1 = get_byte(s, c*4+1);
         a2 = get_byte(s, c*4+2);
         a3 = get_byte(s, c*4+3);
         t[BLOCK_W-1-8*(c*4)   -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
         t[BLOCK_W-1-8*(c*4+1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
         t[BLOCK_W-1-8*(c*4+2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
         t[BLOCK_W-1-8*(c*4+3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
      return t;
   endfunction

   // inverse mix as a preprocessing step followed by the forward mix
   function automatic block_type inv_mix_cols(block_type s);
      block_type t;
      byte_type a0, a1, a2, a3, u, v;
      int c;
      t = '0;
      for (c = 0; c < 4; c++) begin
         a0 = get_byte(s, c*4);
         a1 = get_byte(s, c*4+1);
         a2 = get_byte(s, c*4+2);
         a3 = get_byte(s, c*4+3);
         u = xtime(xtime(a0 ^ a2));
         v = xtime(xtime(a1 ^ a3));
         t[BLOCK_W-1-8*(c*4)   -: 8] = a0 ^ u;
         t[BLOCK_W-1-8*(c*4+1) -: 8] = a1 ^ v;
         t[BLOCK_W-1-8*(c*4+2) -: 8] = a2 ^ u;
         t[BLOCK_W-1-8*(c*4+3) -: 8] = a3 ^ v;
      end
      return mix_cols(t);
   endfunction

   function automatic block_type next_round_key(block_type k, byte_type rc);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96];
      w1 = k[95:64];
      w2 = k[63:32];
      w3 = k[31:0];
      t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

endpackage

@@ rtl/core/aes_key_sched.sv @@
module aes_key_sched
   import aes_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  block_type key,
   input  logic      key_write,
   output logic      settling,
   output block_type round_keys [NUM_ROUNDS+1]
);

   // round keys recomputed one round per cycle after a key write or reset;
   // settling stays high until the last round key is valid
   block_type   key_ff [NUM_ROUNDS+1];
   block_type   key_in [NUM_ROUNDS+1];
   logic [3:0]  refill_ff, refill_in;

   always_comb begin
      key_in[0] = key;
      for (int i = 1; i <= NUM_ROUNDS; i++)
         key_in[i] = next_round_key(key_ff[i-1], RCON[i-1]);
   end

   always_comb begin
      if (key_write) begin
         refill_in = 4'(NUM_ROUNDS + 1);
      end else if (refill_ff != 4'd0) begin
         refill_in = refill_ff - 4'd1;
      end else begin
         refill_in = refill_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= NUM_ROUNDS; i++)
         key_ff[i] <= key_in[i];
      if (reset) begin
         refill_ff <= 4'(NUM_ROUNDS + 1);
      end else begin
         refill_ff <= refill_in;
      end
   end

   assign round_keys = key_ff;
   assign settling   = (refill_ff != 4'd0);

endmodule

@@ rtl/core/aes_round.sv @@
module aes_round
   import aes_pkg::*;
#(
   parameter int unsigned ROUND = 1
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  op_type    in_op,
   input  block_type in_state,
   input  block_type enc_key,
   input  block_type dec_key,
   output logic      out_valid,
   output op_type    out_op,
   output block_type out_state
);

   logic      valid_ff, valid_in;
   op_type    op_ff;
   block_type state_ff, state_in, enc_s, dec_s;

   // decrypt runs the inverse cipher with round key order reversed
   always_comb begin
      enc_s = sub_shift(in_state);
      if (ROUND != NUM_ROUNDS)
         enc_s = mix_cols(enc_s);
      enc_s = enc_s ^ enc_key;
      dec_s = inv_shift_sub(in_state) ^ dec_key;
      if (ROUND != NUM_ROUNDS)
         dec_s = inv_mix_cols(dec_s);
      state_in = (in_op == OP_DECRYPT) ? dec_s : enc_s;
      valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      op_ff    <= in_op;
      state_ff <= state_in;
   end

   assign out_valid = valid_ff;
   assign out_op    = op_ff;
   assign out_state = state_ff;

endmodule

@@ rtl/core/aes128_block_cipher.sv @@
// AES-128 ECB cipher, encrypt or decrypt per block. Unrolled pipeline of ten
// round stages plus an input key-addition stage: a block is taken on every cycle
// in which busy is low, and its result leaves the last round stage with rsp_valid.
// The receiver cannot stall. After reset and after each key write over the csr
// port, busy stays high while the round-key chain refills.
module aes128_block_cipher
   import aes_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_opcode,
   input  logic [63:0] req_block_high,
   input  logic [63:0] req_block_low,
   output logic        rsp_valid,
   output logic [63:0] rsp_result_high,
   output logic [63:0] rsp_result_low,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   logic [63:0] key_high_ff, key_low_ff;
   logic        wr_en;
   logic        settling;
   reg_type     wr_reg;
   block_type   round_keys [NUM_ROUNDS+1];

   assign csr_pready = 1'b1;
   assign busy       = settling;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & (csr_paddr[2:0] == 3'd0);
   assign wr_reg     = reg_type'(csr_paddr[3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (wr_en) begin
         case (wr_reg)
            REG_KEY_HIGH: key_high_ff <= csr_pwdata;
            REG_KEY_LOW:  key_low_ff  <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_type'(csr_paddr[3]))
         REG_KEY_HIGH: csr_prdata = key_high_ff;
         REG_KEY_LOW:  csr_prdata = key_low_ff;
         default:      csr_prdata = '0;
      endcase
      if (csr_paddr[2:0] != 3'd0)
         csr_prdata = '0;
   end

   aes_key_sched u_keys (
      .clock      (clock),
      .reset      (reset),
      .key        ({key_high_ff, key_low_ff}),
      .key_write  (wr_en),
      .settling   (settling),
      .round_keys (round_keys)
   );

   // stage 0: initial key addition
   logic      v0_ff;
   op_type    op0_ff;
   block_type s0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= start & ~busy;
      end
      op0_ff <= op_type'(req_opcode);
      s0_ff  <= {req_block_high, req_block_low}
                ^ (req_opcode ? round_keys[NUM_ROUNDS] : round_keys[0]);
   end

   logic      v_st  [NUM_ROUNDS+1];
   op_type    op_st [NUM_ROUNDS+1];
   block_type s_st  [NUM_ROUNDS+1];

   assign v_st[0]  = v0_ff;
   assign op_st[0] = op0_ff;
   assign s_st[0]  = s0_ff;

   for (genvar g = 1; g <= NUM_ROUNDS; g++) begin : g_round
      aes_round #(.ROUND(g)) u_round (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (v_st[g-1]),
         .in_op     (op_st[g-1]),
         .in_state  (s_st[g-1]),
         .enc_key   (round_keys[g]),
         .dec_key   (round_keys[NUM_ROUNDS-g]),
         .out_valid (v_st[g]),
         .out_op    (op_st[g]),
         .out_state (s_st[g])
      );
   end

   assign rsp_valid       = v_st[NUM_ROUNDS];
   assign rsp_result_high = s_st[NUM_ROUNDS][127:64];
   assign rsp_result_low  = s_st[NUM_ROUNDS][63:0];

endmodule

@@ rtl/core/aes128_block_cipher_checker.sv @@
module aes128_block_cipher_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic csr_pready
);

   property p_ready;
      @(posedge clock) disable iff (reset) csr_pready;
   endproperty
   a_ready: assert property (p_ready) else $error("pready low");

   property p_latency;
      @(posedge clock) disable iff (reset)
         (start && !busy) |-> ##11 rsp_valid;
   endproperty
   a_latency: assert property (p_latency) else $error("result missing");

   property p_no_spurious;
      @(posedge clock) disable iff (reset)
         rsp_valid |-> $past(start && !busy, 11);
   endproperty
   a_no_spurious: assert property (p_no_spurious) else $error("spurious result");

endmodule

bind aes128_block_cipher aes128_block_cipher_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_valid  (rsp_valid),
   .csr_pready (csr_pready)
);

@@ tb/testbench.sv @@
module testbench
   import aes_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 16;

   typedef struct {
      op_type      op;
      logic [63:0] hi;
      logic [63:0] lo;
   } block_req_type;

   typedef struct {
      logic [63:0] hi;
      logic [63:0] lo;
   } cipher_out_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_opcode = 1'b0;
   logic [63:0] req_block_high = '0;
   logic [63:0] req_block_low = '0;
   logic        rsp_valid;
   logic [63:0] rsp_result_high;
   logic [63:0] rsp_result_low;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   block_req_type  pending_blocks[$];
   cipher_out_type expected_blocks[$];
   logic [63:0] cur_key_high = '0;
   logic [63:0] cur_key_low = '0;
   bit          steady = 1'b0;
   int          error_count = 0;
   int          idle_cycles = 0;
   byte_type    fwd_sub [256];
   byte_type    rev_sub [256];

   aes128_block_cipher dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic byte_type gf_mult(byte_type a, byte_type b);
      byte_type acc;
      acc = '0;
      for (int i = 0; i < 8; i++) begin
         if (b[0]) acc ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
         b = b >> 1;
      end
      return acc;
   endfunction

   function automatic byte_type rot8(byte_type x, int n);
      return byte_type'((x << n) | (x >> (8 - n)));
   endfunction

   function automatic block_type shift_state(block_type s, bit inv);
      block_type t;
      int src;
      t = '0;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++) begin
            src = inv ? ((c - r + 4) & 3) : ((c + r) & 3);
            t[127-8*(c*4+r) -: 8] = s[127-8*(src*4+r) -: 8];
         end
      return t;
   endfunction

   function automatic block_type sub_state(block_type s, bit inv);
      block_type t;
      for (int i = 0; i < 16; i++)
         t[127-8*i -: 8] = inv ? rev_sub[s[127-8*i -: 8]] : fwd_sub[s[127-8*i -: 8]];
      return t;
   endfunction

   function automatic block_type mix_state(block_type s, bit inv);
      byte_type fwd [4];
      byte_type bwd [4];
      byte_type col [4];
      byte_type v;
      block_type t;
      fwd = '{8'd2, 8'd3, 8'd1, 8'd1};
      bwd = '{8'd14, 8'd11, 8'd13, 8'd9};
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) col[r] = s[127-8*(c*4+r) -: 8];
         for (int r = 0; r < 4; r++) begin
            v = '0;
            for (int k = 0; k < 4; k++)
               v ^= gf_mult(inv ? bwd[(k - r + 4) & 3] : fwd[(k - r + 4) & 3], col[k]);
            t[127-8*(c*4+r) -: 8] = v;
         end
      end
      return t;
   endfunction

   function automatic cipher_out_type aes_block(block_req_type b, logic [63:0] kh,
                                                logic [63:0] kl);
      logic [31:0] w [44];
      logic [31:0] tw;
      block_type   rk [11];
      block_type   s;
      byte_type    rc;
      cipher_out_type o;
      {w[0], w[1], w[2], w[3]} = {kh, kl};
      rc = 8'h01;
      for (int i = 4; i < 44; i++) begin
         tw = w[i-1];
         if ((i & 3) == 0) begin
            tw = {fwd_sub[tw[23:16]] ^ rc, fwd_sub[tw[15:8]], fwd_sub[tw[7:0]],
                  fwd_sub[tw[31:24]]};
            rc = gf_mult(rc, 8'h02);
         end
         w[i] = w[i-4] ^ tw;
      end
      for (int r = 0; r < 11; r++) rk[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
      s = {b.hi, b.lo};
      if (b.op == OP_ENCRYPT) begin
         s ^= rk[0];
         for (int r = 1; r <= 10; r++) begin
            s = shift_state(sub_state(s, 1'b0), 1'b0);
            if (r != 10) s = mix_state(s, 1'b0);
            s ^= rk[r];
         end
      end else begin
         s ^= rk[10];
         for (int r = 9; r >= 0; r--) begin
            s = sub_state(shift_state(s, 1'b1), 1'b1);
            s ^= rk[r];
            if (r != 0) s = mix_state(s, 1'b1);
         end
      end
      {o.hi, o.lo} = s;
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // driver
   always @(posedge clock) begin : drive
      bit go;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_blocks = {expected_blocks,
                               aes_block(pending_blocks[0], cur_key_high, cur_key_low)};
            pending_blocks.delete(0);
         end
         go = pending_blocks.size() > 0 && (steady || $urandom_range(99) >= 34);
         if (go) begin
            start <= 1'b1;
            req_opcode <= pending_blocks[0].op;
            req_block_high <= pending_blocks[0].hi;
            req_block_low <= pending_blocks[0].lo;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin : watch
      cipher_out_type want;
      if (!reset && rsp_valid) begin
         if (expected_blocks.size() == 0) begin
            report_mismatch("unexpected result transfer", rsp_result_high, '0);
         end else begin
            want = expected_blocks[0];
            expected_blocks.delete(0);
            if (rsp_result_high !== want.hi) report_mismatch("result_high", rsp_result_high, want.hi);
            if (rsp_result_low !== want.lo) report_mismatch("result_low", rsp_result_low, want.lo);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic csr_write(logic [3:0] addr, logic [63:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic load_key(logic [63:0] kh, logic [63:0] kl);
      csr_write(4'(8 * REG_KEY_HIGH), kh);
      csr_write(4'(8 * REG_KEY_LOW), kl);
      cur_key_high = kh;
      cur_key_low = kl;
      // round-key chain refill
      repeat (14) @(negedge clock);
   endtask

   task automatic queue_block(op_type op, logic [63:0] hi, logic [63:0] lo);
      block_req_type b;
      b.op = op;
      b.hi = hi;
      b.lo = lo;
      pending_blocks = {pending_blocks, b};
   endtask

   task automatic queue_random(int n);
      for (int i = 0; i < n; i++)
         queue_block(op_type'($urandom_range(1)), {$urandom, $urandom}, {$urandom, $urandom});
   endtask

   task automatic drain;
      while (pending_blocks.size() > 0 || expected_blocks.size() > 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      byte_type inv_b;
      for (int x = 0; x < 256; x++) begin
         inv_b = 8'h01;
         for (int e = 0; e < 254; e++) inv_b = gf_mult(inv_b, byte_type'(x));
         fwd_sub[x] = inv_b ^ rot8(inv_b, 1) ^ rot8(inv_b, 2) ^ rot8(inv_b, 3)
                      ^ rot8(inv_b, 4) ^ 8'h63;
      end
      for (int x = 0; x < 256; x++) rev_sub[fwd_sub[x]] = byte_type'(x);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset key
      queue_block(OP_ENCRYPT, '0, '0);
      queue_block(OP_DECRYPT, '0, '0);
      queue_block(OP_ENCRYPT, '1, '1);
      queue_block(OP_DECRYPT, '1, '1);
      drain();

      load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
      queue_block(OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
      queue_block(OP_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
      queue_block(OP_ENCRYPT, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
      queue_block(OP_DECRYPT, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
      queue_block(OP_ENCRYPT, 64'h8000000000000000, 64'h0000000000000001);
      queue_block(OP_DECRYPT, 64'h0000000000000001, 64'h8000000000000000);
      drain();

      load_key('1, '1);
      queue_block(OP_ENCRYPT, '0, '0);
      queue_block(OP_DECRYPT, '0, '0);
      queue_block(OP_ENCRYPT, '1, '1);
      queue_block(OP_DECRYPT, '1, '1);
      queue_random(100);
      drain();

      load_key('0, '0);
      queue_random(100);
      drain();

      // back-to-back transfers
      steady = 1'b1;
      load_key({$urandom, $urandom}, {$urandom, $urandom});
      queue_random(300);
      drain();
      steady = 1'b0;

      for (int p = 0; p < 10; p++) begin
         load_key({$urandom, $urandom}, {$urandom, $urandom});
         queue_random(100);
         drain();
      end

      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/aes_pkg.sv
rtl/core/aes_key_sched.sv
rtl/core/aes_round.sv
rtl/core/aes128_block_cipher.sv
rtl/core/aes128_block_cipher_checker.sv
tb/testbench.sv
